/* sv/bdc_pkg.sv */
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies.
package bdc_pkg;

	localparam int COORD_W     = 10;
	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = T_FRAC_BITS + 1;
	localparam int FX_W        = COORD_W + T_FRAC_BITS;
	localparam int NUM_REGS    = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int NUM_PTS     = 4;
	localparam int NUM_AXES    = 2;

	// register map: x and y of each control point, points in order
	localparam logic [CFG_IDX_W-1:0] REG_P0_X  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_P0_Y  = CFG_IDX_W'(1);
	localparam int                   PT_STRIDE = 2;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [FX_W-1:0]    fx_t;
	typedef logic [T_W-1:0]     tpar_t;

endpackage

/* sv/bdc_cfg_regs.sv */
// Control point register file, written through the plain write port.
// Depends on bdc_pkg.
module bdc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  bdc_pkg::coord_t           cfg_wdata,
	output bdc_pkg::coord_t           ctrl [bdc_pkg::NUM_REGS]
);
	import bdc_pkg::*;

	localparam int SEL_W = $clog2(NUM_REGS);

	coord_t ctrl_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				ctrl_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < NUM_REGS)) begin
			ctrl_q[cfg_index[SEL_W-1:0]] <= cfg_wdata;
		end
	end

	assign ctrl = ctrl_q;

endmodule

/* sv/bdc_lerp_cell.sv */
// One interpolation cell: floor((1-t)*a + t*b) as a + floor(t*(b-a)), registered.
// Depends on bdc_pkg.
module bdc_lerp_cell (
	input  logic          clk,
	input  bdc_pkg::fx_t   a,
	input  bdc_pkg::fx_t   b,
	input  bdc_pkg::tpar_t t,
	output bdc_pkg::fx_t   y
);
	import bdc_pkg::*;

	localparam int DIFF_W = FX_W + 1;
	localparam int PROD_W = DIFF_W + T_W + 1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	fx_t                      y_q;

	assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
	assign prod = $signed({1'b0, t}) * diff;

	always_ff @(posedge clk) begin
		y_q <= a + prod[T_FRAC_BITS +: FX_W];
	end

	assign y = y_q;

endmodule

/* sv/bezier_de_casteljau_point.sv */
// Cubic Bezier point evaluator: three rows of interpolation cells per axis.
// An accepted start reaches done through valid_s1 to valid_s4; one request per cycle, busy stays low.
// Throughput set by the cell row: each row holds one request per cycle.
// arst_n clears the control points to 0 and empties the pipeline.
// Depends on bdc_pkg, bdc_cfg_regs, bdc_lerp_cell.
module bezier_de_casteljau_point (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bdc_pkg::tpar_t                t_param,
	input  logic                          cfg_we,
	input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  bdc_pkg::coord_t               cfg_wdata,
	output logic                          done,
	output bdc_pkg::coord_t               pixel_x,
	output bdc_pkg::coord_t               pixel_y
);
	import bdc_pkg::*;

	coord_t ctrl [NUM_REGS];
	tpar_t  t_s1, t_s2, t_s3;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	fx_t    lvl1_s2 [NUM_AXES][NUM_PTS-1];
	fx_t    lvl2_s3 [NUM_AXES][NUM_PTS-2];
	fx_t    lvl3_s4 [NUM_AXES];
	fx_t    pt_fx   [NUM_AXES][NUM_PTS];

	bdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// saturate t above one
	always_ff @(posedge clk) begin
		t_s1 <= (t_param > T_ONE) ? T_ONE : t_param;
		t_s2 <= t_s1;
		t_s3 <= t_s2;
	end

	for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
		for (genvar p = 0; p < NUM_PTS; p++) begin : g_pt
			assign pt_fx[ax][p] = {ctrl[32'(REG_P0_X) + PT_STRIDE * p + ax],
				T_FRAC_BITS'(0)};
		end
		for (genvar k = 0; k < NUM_PTS - 1; k++) begin : g_l1
			bdc_lerp_cell u_cell (
				.clk (clk),
				.a   (pt_fx[ax][k]),
				.b   (pt_fx[ax][k+1]),
				.t   (t_s1),
				.y   (lvl1_s2[ax][k])
			);
		end
		for (genvar k = 0; k < NUM_PTS - 2; k++) begin : g_l2
			bdc_lerp_cell u_cell (
				.clk (clk),
				.a   (lvl1_s2[ax][k]),
				.b   (lvl1_s2[ax][k+1]),
				.t   (t_s2),
				.y   (lvl2_s3[ax][k])
			);
		end
		bdc_lerp_cell u_l3 (
			.clk (clk),
			.a   (lvl2_s3[ax][0]),
			.b   (lvl2_s3[ax][1]),
			.t   (t_s3),
			.y   (lvl3_s4[ax])
		);
	end

	assign done    = valid_s4;
	assign pixel_x = lvl3_s4[32'(REG_P0_X)][FX_W-1:T_FRAC_BITS];
	assign pixel_y = lvl3_s4[32'(REG_P0_Y)][FX_W-1:T_FRAC_BITS];

endmodule

/* sv/bdc_chk.sv */
// Port-level checker for the Bezier point evaluator, bound to the top level.
// Depends on bdc_pkg.
module bdc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input bdc_pkg::tpar_t                t_param,
	input logic                          cfg_we,
	input logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input bdc_pkg::coord_t               cfg_wdata,
	input logic                          done,
	input bdc_pkg::coord_t               pixel_x,
	input bdc_pkg::coord_t               pixel_y
);
	import bdc_pkg::*;

	logic accept;
	assign accept = start && !busy;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("request not answered after four cycles");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("done without matching request");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_done_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({pixel_x, pixel_y}))
		else $error("unknown point on done");

	a_inputs_known: assert property (@(posedge clk) disable iff (!arst_n)
		(accept || cfg_we) |-> !$isunknown({t_param, cfg_index, cfg_wdata}))
		else $error("unknown request or register write");

endmodule

bind bezier_de_casteljau_point bdc_chk u_bdc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.t_param   (t_param),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata),
	.done      (done),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y)
);
